/* rtl/bmh_pkg.sv */
// Shared operation codes, widths and controller/datapath interface types for the heap engine.
`timescale 1ns / 1ps

package bmh_pkg;

  localparam int OP_W     = 3;
  localparam int IDX_W    = 8;
  localparam int KEY_IN_W = 32;
  localparam int PAY_W    = 16;
  localparam int CNT_IN_W = 9;

  localparam logic [OP_W-1:0] OP_WRITE     = 3'd0;
  localparam logic [OP_W-1:0] OP_SET_COUNT = 3'd1;
  localparam logic [OP_W-1:0] OP_SIFT_DOWN = 3'd2;
  localparam logic [OP_W-1:0] OP_SIFT_UP   = 3'd3;
  localparam logic [OP_W-1:0] OP_BUILD     = 3'd4;
  localparam logic [OP_W-1:0] OP_READ      = 3'd5;

  // Memory read address sources.
  typedef enum logic [2:0] {
    RSEL_IDX,
    RSEL_LEFT,
    RSEL_RIGHT,
    RSEL_PARENT,
    RSEL_BIDX
  } rsel_t;

  // Memory write sources.
  typedef enum logic [1:0] {
    WSEL_INPUT,
    WSEL_CHILD,
    WSEL_PARENT,
    WSEL_NODE
  } wsel_t;

  // Position register sources.
  typedef enum logic [1:0] {
    PSEL_IDX,
    PSEL_CHILD,
    PSEL_PARENT,
    PSEL_BIDX
  } psel_t;

  typedef struct packed {
    logic  latch_in;
    logic  mem_rd;
    rsel_t rd_sel;
    logic  mem_wr;
    wsel_t wr_sel;
    logic  pos_en;
    psel_t pos_sel;
    logic  cap_node;
    logic  cap_left;
    logic  set_count;
    logic  bidx_load;
    logic  bidx_dec;
    logic  res_read;
    logic  res_bad;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            idx_live;
    logic            idx_zero;
    logic            pos_zero;
    logic            left_ok;
    logic            move_down;
    logic            parent_gt;
    logic            bidx_live;
    logic            bidx_zero;
    logic            out_free;
  } stat_t;

endpackage

/* rtl/bmh_dp.sv */
// Datapath of the heap engine: entry memory, sift registers, count and result registers.
`timescale 1ns / 1ps

module bmh_dp
  import bmh_pkg::*;
#(
  parameter int HEAP_DEPTH = 256,
  parameter int KEY_BITS   = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output stat_t               stat,
  input  logic [OP_W-1:0]     operation,
  input  logic [IDX_W-1:0]    index,
  input  logic [KEY_IN_W-1:0] entry_key,
  input  logic [PAY_W-1:0]    entry_payload,
  input  logic [CNT_IN_W-1:0] new_count,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [KEY_IN_W-1:0] read_key,
  output logic [PAY_W-1:0]    read_payload,
  output logic                status
);

  localparam int AW      = $clog2(HEAP_DEPTH);
  localparam int CNT_MAX = (HEAP_DEPTH < (1 << CNT_IN_W) - 1) ? HEAP_DEPTH
                                                                : (1 << CNT_IN_W) - 1;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);
  localparam int CW      = AW + 2;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [PAY_W-1:0]    payload;
  } ent_t;

  ent_t mem [HEAP_DEPTH];

  logic [OP_W-1:0]     item_op;
  logic [IDX_W-1:0]    item_idx;
  logic [KEY_IN_W-1:0] item_key;
  logic [PAY_W-1:0]    item_payload;
  logic [CNT_IN_W-1:0] item_count;

  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    bidx;
  logic [AW-1:0]       pos;
  ent_t                node;
  ent_t                left_ent;
  ent_t                rdata;

  logic [KEY_IN_W-1:0] res_key;
  logic [PAY_W-1:0]    res_payload;
  logic                res_status;

  logic [CW-1:0]       left_c;
  logic [CW-1:0]       right_c;
  logic [AW-1:0]       pos_m1;
  logic [AW-1:0]       parent_c;
  logic                right_ok;
  logic                take_left;
  logic                take_right;
  logic [AW-1:0]       child_c;
  ent_t                child_ent;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;
  ent_t                wr_data;
  logic                wr_en;
  logic                out_free;

  assign left_c   = (CW'(pos) << 1) + CW'(1);
  assign right_c  = (CW'(pos) << 1) + CW'(2);
  assign pos_m1   = pos - AW'(1);
  assign parent_c = pos_m1 >> 1;
  assign right_ok = 32'(right_c) < 32'(count);

  // Left child wins when it is strictly smaller; the right one replaces it only if strictly
  // smaller than the current best.
  assign take_left  = left_ent.key < node.key;
  assign take_right = right_ok && (take_left ? (rdata.key < left_ent.key)
                                             : (rdata.key < node.key));
  assign child_c    = take_right ? AW'(right_c) : AW'(left_c);
  assign child_ent  = take_right ? rdata : left_ent;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    stat.op        = item_op;
    stat.idx_live  = 32'(item_idx) < 32'(count);
    stat.idx_zero  = item_idx == '0;
    stat.pos_zero  = pos == '0;
    stat.left_ok   = 32'(left_c) < 32'(count);
    stat.move_down = take_left || take_right;
    stat.parent_gt = rdata.key > node.key;
    stat.bidx_live = bidx < count;
    stat.bidx_zero = bidx == '0;
    stat.out_free  = out_free;
  end

  always_comb begin
    case (cmd.rd_sel)
      RSEL_IDX:    rd_addr = AW'(item_idx);
      RSEL_LEFT:   rd_addr = AW'(left_c);
      RSEL_RIGHT:  rd_addr = AW'(right_c);
      RSEL_PARENT: rd_addr = parent_c;
      RSEL_BIDX:   rd_addr = AW'(bidx);
      default:     rd_addr = '0;
    endcase
  end

  always_comb begin
    wr_en = cmd.mem_wr;
    case (cmd.wr_sel)
      WSEL_INPUT: begin
        wr_addr = AW'(item_idx);
        wr_data = '{key: KEY_BITS'(item_key), payload: item_payload};
        wr_en   = cmd.mem_wr && (32'(item_idx) < HEAP_DEPTH);
      end
      WSEL_CHILD: begin
        wr_addr = pos;
        wr_data = child_ent;
      end
      WSEL_PARENT: begin
        wr_addr = pos;
        wr_data = rdata;
      end
      WSEL_NODE: begin
        wr_addr = pos;
        wr_data = node;
      end
      default: begin
        wr_addr = pos;
        wr_data = node;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.mem_rd) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      item_op      <= operation;
      item_idx     <= index;
      item_key     <= entry_key;
      item_payload <= entry_payload;
      item_count   <= new_count;
    end
    if (cmd.cap_node) begin
      node <= rdata;
    end
    if (cmd.cap_left) begin
      left_ent <= rdata;
    end
    if (cmd.pos_en) begin
      case (cmd.pos_sel)
        PSEL_IDX:    pos <= AW'(item_idx);
        PSEL_CHILD:  pos <= child_c;
        PSEL_PARENT: pos <= parent_c;
        PSEL_BIDX:   pos <= AW'(bidx);
        default:     pos <= pos;
      endcase
    end
    if (cmd.bidx_load) begin
      bidx <= count >> 1;
    end else if (cmd.bidx_dec) begin
      bidx <= bidx - CNT_W'(1);
    end
    if (cmd.latch_in) begin
      res_key     <= '0;
      res_payload <= '0;
      res_status  <= 1'b0;
    end else begin
      if (cmd.res_read) begin
        res_key     <= KEY_IN_W'(rdata.key);
        res_payload <= rdata.payload;
      end
      if (cmd.res_bad) begin
        res_status <= 1'b1;
      end
    end
    if (cmd.out_load) begin
      read_key     <= res_key;
      read_payload <= res_payload;
      status       <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.set_count) begin
        count <= CNT_W'((32'(item_count) > HEAP_DEPTH) ? HEAP_DEPTH : 32'(item_count));
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/bmh_ctrl.sv */
// Controller of the heap engine: sequences decode, reads, sifts, build and result hand-off.
`timescale 1ns / 1ps

module bmh_ctrl
  import bmh_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RD_WAIT,
    S_DN_NODE,
    S_DN_NEXT,
    S_DN_LEFT,
    S_DN_RIGHT,
    S_DN_END,
    S_UP_NODE,
    S_UP_NEXT,
    S_UP_PARENT,
    S_UP_END,
    S_BLD_NEXT,
    S_BLD_STEP,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = state != S_IDLE;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_DONE;
        unique case (stat.op)
          OP_WRITE: begin
            cmd.mem_wr = 1'b1;
            cmd.wr_sel = WSEL_INPUT;
          end
          OP_SET_COUNT: begin
            cmd.set_count = 1'b1;
          end
          OP_SIFT_DOWN: begin
            if (stat.idx_live) begin
              cmd.pos_en  = 1'b1;
              cmd.pos_sel = PSEL_IDX;
              cmd.mem_rd  = 1'b1;
              cmd.rd_sel  = RSEL_IDX;
              state_next  = S_DN_NODE;
            end
          end
          OP_SIFT_UP: begin
            if (stat.idx_live && !stat.idx_zero) begin
              cmd.pos_en  = 1'b1;
              cmd.pos_sel = PSEL_IDX;
              cmd.mem_rd  = 1'b1;
              cmd.rd_sel  = RSEL_IDX;
              state_next  = S_UP_NODE;
            end
          end
          OP_BUILD: begin
            cmd.bidx_load = 1'b1;
            state_next    = S_BLD_NEXT;
          end
          OP_READ: begin
            if (stat.idx_live) begin
              cmd.mem_rd = 1'b1;
              cmd.rd_sel = RSEL_IDX;
              state_next = S_RD_WAIT;
            end else begin
              cmd.res_bad = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      S_RD_WAIT: begin
        cmd.res_read = 1'b1;
        state_next   = S_DONE;
      end
      // The sinking entry is held in the node register and written once at its final place.
      S_DN_NODE: begin
        cmd.cap_node = 1'b1;
        cmd.mem_rd   = 1'b1;
        cmd.rd_sel   = RSEL_LEFT;
        state_next   = S_DN_LEFT;
      end
      S_DN_NEXT: begin
        cmd.mem_rd = 1'b1;
        cmd.rd_sel = RSEL_LEFT;
        state_next = S_DN_LEFT;
      end
      S_DN_LEFT: begin
        if (stat.left_ok) begin
          cmd.cap_left = 1'b1;
          cmd.mem_rd   = 1'b1;
          cmd.rd_sel   = RSEL_RIGHT;
          state_next   = S_DN_RIGHT;
        end else begin
          state_next = S_DN_END;
        end
      end
      S_DN_RIGHT: begin
        if (stat.move_down) begin
          cmd.mem_wr  = 1'b1;
          cmd.wr_sel  = WSEL_CHILD;
          cmd.pos_en  = 1'b1;
          cmd.pos_sel = PSEL_CHILD;
          state_next  = S_DN_NEXT;
        end else begin
          state_next = S_DN_END;
        end
      end
      S_DN_END: begin
        cmd.mem_wr = 1'b1;
        cmd.wr_sel = WSEL_NODE;
        state_next = (stat.op == OP_BUILD) ? S_BLD_STEP : S_DONE;
      end
      S_UP_NODE: begin
        cmd.cap_node = 1'b1;
        cmd.mem_rd   = 1'b1;
        cmd.rd_sel   = RSEL_PARENT;
        state_next   = S_UP_PARENT;
      end
      S_UP_NEXT: begin
        if (stat.pos_zero) begin
          state_next = S_UP_END;
        end else begin
          cmd.mem_rd = 1'b1;
          cmd.rd_sel = RSEL_PARENT;
          state_next = S_UP_PARENT;
        end
      end
      S_UP_PARENT: begin
        if (stat.parent_gt) begin
          cmd.mem_wr  = 1'b1;
          cmd.wr_sel  = WSEL_PARENT;
          cmd.pos_en  = 1'b1;
          cmd.pos_sel = PSEL_PARENT;
          state_next  = S_UP_NEXT;
        end else begin
          state_next = S_UP_END;
        end
      end
      S_UP_END: begin
        cmd.mem_wr = 1'b1;
        cmd.wr_sel = WSEL_NODE;
        state_next = S_DONE;
      end
      S_BLD_NEXT: begin
        if (stat.bidx_live) begin
          cmd.pos_en  = 1'b1;
          cmd.pos_sel = PSEL_BIDX;
          cmd.mem_rd  = 1'b1;
          cmd.rd_sel  = RSEL_BIDX;
          state_next  = S_DN_NODE;
        end else begin
          state_next = S_BLD_STEP;
        end
      end
      S_BLD_STEP: begin
        if (stat.bidx_zero) begin
          state_next = S_DONE;
        end else begin
          cmd.bidx_dec = 1'b1;
          state_next   = S_BLD_NEXT;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/binary_min_heap_engine.sv */
// Binary min-heap engine: one operation per item on a memory-backed heap, one result item each.
// Sift down moves the entry one level per step until it stops above a child or reaches a leaf;
// sift up moves it until it stops below a parent or reaches the root; build runs a sift down
// at each position count/2..0 that lies below count. Each item is finished before the next
// is taken, and a stalled result holds the next item off.
// Reset clears count and output valid, not entries.
`timescale 1ns / 1ps

module binary_min_heap_engine
  import bmh_pkg::*;
#(
  parameter int HEAP_DEPTH = 256,
  parameter int KEY_BITS   = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OP_W-1:0]     operation,
  input  logic [IDX_W-1:0]    index,
  input  logic [KEY_IN_W-1:0] entry_key,
  input  logic [PAY_W-1:0]    entry_payload,
  input  logic [CNT_IN_W-1:0] new_count,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [KEY_IN_W-1:0] read_key,
  output logic [PAY_W-1:0]    read_payload,
  output logic                status
);

  cmd_t  cmd;
  stat_t stat;

  bmh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bmh_dp #(
    .HEAP_DEPTH (HEAP_DEPTH),
    .KEY_BITS   (KEY_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .operation     (operation),
    .index         (index),
    .entry_key     (entry_key),
    .entry_payload (entry_payload),
    .new_count     (new_count),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .read_key      (read_key),
    .read_payload  (read_payload),
    .status        (status)
  );

endmodule

/* bench/testbench.sv */
// Self-checking testbench for the binary min-heap engine: directed cases, then random heap sessions.
`timescale 1ns / 1ps

module testbench;
  import bmh_pkg::*;

  localparam int DEPTH = 256;
  localparam int QUIET_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 64;
  localparam int ITEMS_PER_PHASE = 400;
  localparam int MAX_REPORTS = 10;

  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [KEY_IN_W-1:0] key;
    logic [PAY_W-1:0]    payload;
    logic                bad_index;
  } heap_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     operation = OP_WRITE;
  logic [IDX_W-1:0]    index = '0;
  logic [KEY_IN_W-1:0] entry_key = '0;
  logic [PAY_W-1:0]    entry_payload = '0;
  logic [CNT_IN_W-1:0] new_count = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [KEY_IN_W-1:0] read_key;
  logic [PAY_W-1:0]    read_payload;
  logic                status;

  // Predicted heap contents, kept in step with every accepted item.
  logic [KEY_IN_W-1:0] heap_key_model[DEPTH];
  logic [PAY_W-1:0]    heap_payload_model[DEPTH];
  int                  heap_size_model = 0;

  heap_result_t pending_results[$];
  heap_result_t oldest_result;
  int           mismatch_count = 0;
  int           items_sent = 0;
  int           quiet_cycles = 0;
  int           send_idle_pct = 33;
  int           recv_idle_pct = 58;

  binary_min_heap_engine dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .index        (index),
    .entry_key    (entry_key),
    .entry_payload(entry_payload),
    .new_count    (new_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .read_key     (read_key),
    .read_payload (read_payload),
    .status       (status)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void swap_entries(input int a, input int b);
    logic [KEY_IN_W-1:0] k;
    logic [PAY_W-1:0]    p;
    k = heap_key_model[a];
    p = heap_payload_model[a];
    heap_key_model[a] = heap_key_model[b];
    heap_payload_model[a] = heap_payload_model[b];
    heap_key_model[b] = k;
    heap_payload_model[b] = p;
  endfunction

  function automatic void sift_down_model(input int start);
    int  pos;
    int  left;
    int  right;
    int  best;
    bit  settled;
    pos = start;
    settled = 1'b0;
    while (!settled) begin
      left = 2 * pos + 1;
      right = 2 * pos + 2;
      best = pos;
      // A strict compare on the left first means a tie between children goes left.
      if (left < heap_size_model && heap_key_model[left] < heap_key_model[best]) best = left;
      if (right < heap_size_model && heap_key_model[right] < heap_key_model[best]) best = right;
      if (best == pos) begin
        settled = 1'b1;
      end else begin
        swap_entries(pos, best);
        pos = best;
      end
    end
  endfunction

  function automatic void sift_up_model(input int start);
    int pos;
    int up;
    bit settled;
    pos = start;
    settled = 1'b0;
    while (!settled && pos < heap_size_model && pos != 0) begin
      up = (pos - 1) / 2;
      if (heap_key_model[up] <= heap_key_model[pos]) begin
        settled = 1'b1;
      end else begin
        swap_entries(up, pos);
        pos = up;
      end
    end
  endfunction

  function automatic heap_result_t predict_heap_op(
    input logic [OP_W-1:0]     op,
    input logic [IDX_W-1:0]    idx,
    input logic [KEY_IN_W-1:0] key,
    input logic [PAY_W-1:0]    pay,
    input logic [CNT_IN_W-1:0] cnt
  );
    heap_result_t r;
    int           i;
    r = '0;
    case (op)
      OP_WRITE: begin
        heap_key_model[idx] = key;
        heap_payload_model[idx] = pay;
      end
      OP_SET_COUNT: heap_size_model = (cnt > DEPTH) ? DEPTH : int'(cnt);
      OP_SIFT_DOWN: if (int'(idx) < heap_size_model) sift_down_model(int'(idx));
      OP_SIFT_UP: sift_up_model(int'(idx));
      OP_BUILD: begin
        for (i = heap_size_model / 2; i >= 0; i--) begin
          if (i < heap_size_model) sift_down_model(i);
        end
      end
      OP_READ: begin
        if (int'(idx) < heap_size_model) begin
          r.key = heap_key_model[idx];
          r.payload = heap_payload_model[idx];
        end else begin
          r.bad_index = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- driving

  task automatic send_item(
    input logic [OP_W-1:0]     op,
    input logic [IDX_W-1:0]    idx,
    input logic [KEY_IN_W-1:0] key,
    input logic [PAY_W-1:0]    pay,
    input logic [CNT_IN_W-1:0] cnt
  );
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    index <= idx;
    entry_key <= key;
    entry_payload <= pay;
    new_count <= cnt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_heap_op(op, idx, key, pay, cnt));
    items_sent++;
  endtask

  task automatic do_write(input int idx, input logic [KEY_IN_W-1:0] key,
                          input logic [PAY_W-1:0] pay);
    send_item(OP_WRITE, IDX_W'(idx), key, pay, CNT_IN_W'($urandom));
  endtask

  task automatic do_set_count(input int cnt);
    send_item(OP_SET_COUNT, IDX_W'($urandom), $urandom, PAY_W'($urandom), CNT_IN_W'(cnt));
  endtask

  task automatic do_op(input logic [OP_W-1:0] op, input int idx);
    send_item(op, IDX_W'(idx), $urandom, PAY_W'($urandom), CNT_IN_W'($urandom));
  endtask

  // Small key ranges force ties, which exercise the left-child preference.
  function automatic logic [KEY_IN_W-1:0] pick_key(input int style);
    logic [KEY_IN_W-1:0] k;
    case (style)
      0: k = $urandom_range(7);
      1: k = $urandom;
      default: begin
        case ($urandom_range(3))
          0: k = '0;
          1: k = '1;
          2: k = 32'h8000_0000;
          default: k = $urandom_range(3);
        endcase
      end
    endcase
    return k;
  endfunction

  task automatic read_whole_heap();
    int k;
    for (k = 0; k < heap_size_model; k++) do_op(OP_READ, k);
  endtask

  task automatic pop_min();
    int last;
    if (heap_size_model > 0) begin
      last = heap_size_model - 1;
      do_op(OP_READ, 0);
      do_write(0, heap_key_model[last], heap_payload_model[last]);
      do_set_count(last);
      do_op(OP_SIFT_DOWN, 0);
    end
  endtask

  task automatic push_entry(input logic [KEY_IN_W-1:0] key);
    int slot;
    if (heap_size_model < DEPTH) begin
      slot = heap_size_model;
      do_set_count(slot + 1);
      do_write(slot, key, PAY_W'($urandom));
      do_op(OP_SIFT_UP, slot);
    end
  endtask

  task automatic rekey_entry(input logic [KEY_IN_W-1:0] key);
    int pos;
    if (heap_size_model > 0) begin
      pos = $urandom_range(heap_size_model - 1);
      do_write(pos, key, PAY_W'($urandom));
      do_op(OP_SIFT_UP, pos);
      do_op(OP_SIFT_DOWN, pos);
    end
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- checking

  task automatic flag_mismatch(input string what, input logic [KEY_IN_W-1:0] want,
                               input logic [KEY_IN_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch in %s at %0t: expected %h, got %h", what, $realtime, want, got);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with nothing outstanding", '0, read_key);
      end else begin
        oldest_result = pending_results.pop_front();
        if (read_key !== oldest_result.key)
          flag_mismatch("read_key", oldest_result.key, read_key);
        if (read_payload !== oldest_result.payload)
          flag_mismatch("read_payload", KEY_IN_W'(oldest_result.payload),
                        KEY_IN_W'(read_payload));
        if (status !== oldest_result.bad_index)
          flag_mismatch("status", KEY_IN_W'(oldest_result.bad_index), KEY_IN_W'(status));
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && ((in_valid && !in_stall) || (out_valid && !out_stall)))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------- tests

  // Every entry is written once up front, so no later item touches an unwritten entry.
  task automatic fill_heap_array();
    int k;
    for (k = 0; k < DEPTH; k++) do_write(k, pick_key(k % 3), PAY_W'($urandom));
  endtask

  task automatic test_count_and_bad_reads();
    do_set_count(0);
    do_op(OP_READ, 0);
    do_op(OP_SIFT_DOWN, 0);
    do_op(OP_SIFT_UP, 5);
    do_op(OP_BUILD, 0);
    do_set_count(511);
    do_op(OP_READ, DEPTH - 1);
    do_op(OP_READ, 0);
  endtask

  task automatic test_tie_and_root();
    do_write(0, 32'd9, 16'h0000);
    do_write(1, 32'd4, 16'haaaa);
    do_write(2, 32'd4, 16'h5555);
    do_set_count(3);
    do_op(OP_SIFT_DOWN, 0);
    do_op(OP_READ, 1);
    do_op(OP_SIFT_UP, 0);
    do_write(2, '0, 16'hffff);
    do_op(OP_SIFT_UP, 2);
    do_op(OP_READ, 0);
    do_write(1, '1, '1);
    do_set_count(2);
    do_op(OP_READ, 1);
    do_op(OP_READ, 2);
  endtask

  task automatic test_unused_codes();
    do_op(OP_SPARE_6, $urandom);
    do_op(OP_SPARE_7, $urandom);
  endtask

  task automatic test_full_build();
    do_set_count(DEPTH);
    do_op(OP_BUILD, 0);
    do_op(OP_READ, 0);
    do_op(OP_READ, DEPTH - 1);
  endtask

  // Arbitrary items with any code and field values; all entries are written, so all are safe.
  task automatic send_noise();
    int n;
    logic [CNT_IN_W-1:0] cnt;
    n = $urandom_range(1, 8);
    repeat (n) begin
      cnt = ($urandom_range(7) == 0) ? CNT_IN_W'($urandom) : CNT_IN_W'($urandom_range(40));
      send_item(OP_W'($urandom_range(7)), IDX_W'($urandom), $urandom, PAY_W'($urandom), cnt);
    end
  endtask

  task automatic run_heap_session();
    int size;
    int style;
    int k;
    bit grow_by_push;
    style = $urandom_range(2);
    size = ($urandom_range(19) == 0) ? DEPTH : $urandom_range(1, 31);
    grow_by_push = (size < DEPTH) && $urandom_range(1);
    if (grow_by_push) begin
      do_set_count(0);
      for (k = 0; k < size; k++) push_entry(pick_key(style));
    end else begin
      do_set_count((size == DEPTH) ? $urandom_range(DEPTH, 511) : size);
      for (k = 0; k < size; k++) do_write(k, pick_key(style), PAY_W'($urandom));
      do_op(OP_BUILD, $urandom);
    end
    read_whole_heap();
    if (size < DEPTH) do_op(OP_READ, $urandom_range(size, DEPTH - 1));
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(3))
        0: pop_min();
        1: push_entry(pick_key(style));
        2: rekey_entry(pick_key(style));
        default: do_op(OP_READ, $urandom_range(heap_size_model));
      endcase
    end
    if (heap_size_model <= 40) read_whole_heap();
    else do_op(OP_READ, 0);
  endtask

  task automatic run_random_phase(input int sender_pct, input int receiver_pct);
    int start;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    start = items_sent;
    while (items_sent - start < ITEMS_PER_PHASE) begin
      if ($urandom_range(9) < 2) send_noise();
      else run_heap_session();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    fill_heap_array();
    test_count_and_bad_reads();
    test_tie_and_root();
    test_unused_codes();
    test_full_build();
    run_random_phase(33, 58);
    run_random_phase(58, 33);
    run_random_phase(0, 0);
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
